[hdl/lru_buffer_directory_assert.svh]
// Assertion macros for the directory block.
`ifndef LRU_BUFFER_DIRECTORY_ASSERT_SVH
`define LRU_BUFFER_DIRECTORY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lbd_pkg.sv]
package lbd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = 5;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_FREE   = 2'd2
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] len;
        logic [DATA_W-1:0] stamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_OLDEST,
        S_SHIFT,
        S_APPEND,
        S_OUT
    } t_state;

endpackage

[hdl/lru_buffer_directory.sv]
// Lookup: reads entries in index order until the first matching id, then responds.
// Insert when full: id scan, oldest scan, shift, append.
// Free by index: shifts the later entries down; free-all or bad index needs no shift.
// One request in flight: requests are taken only in the idle state.
// A new request is taken while the previous response still waits in the output register.
// Reset (sync, active low) clears entry count, use counter and control; RAM is not cleared.
`include "lru_buffer_directory_assert.svh"

module lru_buffer_directory (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lbd_pkg::OP_W-1:0]    i_op,
    input  logic [lbd_pkg::DATA_W-1:0]  i_entry_id,
    input  logic [lbd_pkg::DATA_W-1:0]  i_entry_length,
    input  logic [lbd_pkg::IDX_W-1:0]   i_free_index,
    // response channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lbd_pkg::IDX_W-1:0]   o_result_index,
    output logic                        o_hit,
    output logic [lbd_pkg::DATA_W-1:0]  o_found_length,
    output logic                        o_status
);
    import lbd_pkg::*;

    // Entry RAM: id, length, stamp per slot; one read, one write port.
    t_entry              r_entry_mem [MAX_ENTRIES];
    t_entry              r_rdata;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_counter, n_counter;

    // captured request
    logic [OP_W-1:0]     r_op, n_op;
    logic [DATA_W-1:0]   r_id, n_id;
    logic [DATA_W-1:0]   r_len, n_len;

    // streaming scan: next read address, pending read flag and its address
    logic [IDX_W-1:0]    r_rptr, n_rptr;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_cptr, n_cptr;

    // oldest-entry search
    logic [DATA_W-1:0]   r_min, n_min;
    logic [ADDR_W-1:0]   r_best, n_best;

    // staged response
    logic [IDX_W-1:0]    r_res_index, n_res_index;
    logic                r_res_hit, n_res_hit;
    logic [DATA_W-1:0]   r_res_len, n_res_len;
    logic                r_res_status, n_res_status;

    // output register
    logic                r_out_vld, n_out_vld;
    logic [IDX_W-1:0]    r_out_index, n_out_index;
    logic                r_out_hit, n_out_hit;
    logic [DATA_W-1:0]   r_out_len, n_out_len;
    logic                r_out_status, n_out_status;

    // RAM controls
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    t_entry              w_wdata;
    logic                w_re;
    logic [ADDR_W-1:0]   w_raddr;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_rd_more;
    logic                w_match;
    logic                w_drain;
    logic                w_full;
    logic                w_is_lookup;
    logic                w_is_insert;
    logic                w_free_simple;

    assign w_in_acc     = i_valid && o_ready;
    assign w_out_free   = !r_out_vld || i_ready;
    assign w_rd_more    = r_rptr < r_count;
    // scan stops at the first matching id, in index order
    assign w_match      = r_pend && (r_rdata.id == r_id);
    // stream finished: no read in flight and nothing left to read
    assign w_drain      = !r_pend && !w_rd_more;
    assign w_full       = r_count == IDX_W'(MAX_ENTRIES);
    assign w_is_lookup  = r_op == OP_LOOKUP;
    assign w_is_insert  = r_op == OP_INSERT;
    // free-all or out-of-range index: no shifting needed
    assign w_free_simple = (i_free_index == '0) || (i_free_index > r_count);

    assign o_ready        = r_state == S_IDLE;
    assign o_valid        = r_out_vld;
    assign o_result_index = r_out_index;
    assign o_hit          = r_out_hit;
    assign o_found_length = r_out_len;
    assign o_status       = r_out_status;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_op)
                        OP_LOOKUP, OP_INSERT: n_state = S_FIND;
                        OP_FREE:              n_state = w_free_simple ? S_OUT : S_SHIFT;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_FIND: begin
                if (w_match) begin
                    n_state = w_is_lookup ? S_OUT : S_SHIFT;
                end else if (w_drain) begin
                    if (!w_is_insert) begin
                        n_state = S_OUT;
                    end else if (w_full) begin
                        n_state = S_OLDEST;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_OLDEST: begin
                if (w_drain) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_drain) begin
                    n_state = w_is_insert ? S_APPEND : S_OUT;
                end
            end
            S_APPEND: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and RAM controls ----------------
    always_comb begin
        n_count      = r_count;
        n_counter    = r_counter;
        n_op         = r_op;
        n_id         = r_id;
        n_len        = r_len;
        n_rptr       = r_rptr;
        n_pend       = 1'b0;
        n_cptr       = r_cptr;
        n_min        = r_min;
        n_best       = r_best;
        n_res_index  = r_res_index;
        n_res_hit    = r_res_hit;
        n_res_len    = r_res_len;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !i_ready;
        n_out_index  = r_out_index;
        n_out_hit    = r_out_hit;
        n_out_len    = r_out_len;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_cptr;
        w_wdata      = r_rdata;
        w_re         = 1'b0;
        w_raddr      = r_rptr[ADDR_W-1:0];

        // shared streaming read: one entry per cycle in index order
        if ((r_state == S_FIND) || (r_state == S_OLDEST) || (r_state == S_SHIFT)) begin
            w_re   = w_rd_more;
            n_pend = w_rd_more;
            n_cptr = r_rptr[ADDR_W-1:0];
            if (w_rd_more) begin
                n_rptr = r_rptr + 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op         = i_op;
                    n_id         = i_entry_id;
                    n_len        = i_entry_length;
                    n_rptr       = '0;
                    n_res_index  = '0;
                    n_res_hit    = 1'b0;
                    n_res_len    = '0;
                    n_res_status = 1'b0;
                    if (i_op == OP_FREE) begin
                        if (i_free_index == '0) begin
                            n_count = '0;
                        end else if (i_free_index > r_count) begin
                            n_res_status = 1'b1;
                        end else begin
                            // shift starts at the entry after the removed one
                            n_rptr = i_free_index;
                        end
                    end
                end
            end
            S_FIND: begin
                if (w_match) begin
                    n_counter = r_counter + 1'b1;
                    if (w_is_lookup) begin
                        // restamp the hit entry in place
                        w_we        = 1'b1;
                        w_waddr     = r_cptr;
                        w_wdata     = '{id: r_rdata.id, len: r_rdata.len,
                                        stamp: r_counter + 1'b1};
                        n_res_index = IDX_W'(r_cptr) + 1'b1;
                        n_res_hit   = 1'b1;
                        n_res_len   = r_rdata.len;
                    end else begin
                        // insert over an existing id: drop the old copy
                        n_rptr = IDX_W'(r_cptr) + 1'b1;
                        n_pend = 1'b0;
                    end
                end else if (w_drain && w_is_insert && w_full) begin
                    n_rptr = '0;
                    n_pend = 1'b0;
                    n_min  = '1;
                    n_best = '0;
                end
            end
            S_OLDEST: begin
                // <= keeps the last entry on equal stamps
                if (r_pend && (r_rdata.stamp <= r_min)) begin
                    n_min  = r_rdata.stamp;
                    n_best = r_cptr;
                end
                if (w_drain) begin
                    n_rptr = IDX_W'(r_best) + 1'b1;
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_cptr - 1'b1;
                    w_wdata = r_rdata;
                end
                if (w_drain) begin
                    n_count = r_count - 1'b1;
                end
            end
            S_APPEND: begin
                w_we        = 1'b1;
                w_waddr     = r_count[ADDR_W-1:0];
                w_wdata     = '{id: r_id, len: r_len, stamp: r_counter + 1'b1};
                n_counter   = r_counter + 1'b1;
                n_count     = r_count + 1'b1;
                n_res_index = r_count + 1'b1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_index  = r_res_index;
                    n_out_hit    = r_res_hit;
                    n_out_len    = r_res_len;
                    n_out_status = r_res_status;
                end
            end
            default: ;
        endcase
    end

    // ---------------- entry RAM ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_entry_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_entry_mem[w_raddr];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_counter <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_counter <= n_counter;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_len        <= n_len;
        r_rptr       <= n_rptr;
        r_cptr       <= n_cptr;
        r_min        <= n_min;
        r_best       <= n_best;
        r_res_index  <= n_res_index;
        r_res_hit    <= n_res_hit;
        r_res_len    <= n_res_len;
        r_res_status <= n_res_status;
        r_out_index  <= n_out_index;
        r_out_hit    <= n_out_hit;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    // ---------------- assertions ----------------
    `LBD_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= IDX_W'(MAX_ENTRIES), "entry count above capacity")
    `LBD_ASSERT_NOW(a_hit_index, i_clk, i_rst_n, o_valid && o_hit, o_result_index != '0, "hit with zero index")
    `LBD_ASSERT_NEXT(a_append_grow, i_clk, i_rst_n, r_state == S_APPEND, r_count == $past(r_count) + 1'b1, "append did not grow count")
    `LBD_ASSERT_NOW(a_shift_addr, i_clk, i_rst_n, (r_state == S_SHIFT) && w_we, IDX_W'(w_waddr) < r_count, "shift write beyond entries")

endmodule
